### rtl/led_driver_serial_frame_writer_macros.svh
// ----------------------------------------------------------------------------
// led driver serial frame writer assertion macros
// shared concurrent check helpers for the rtl files
// ----------------------------------------------------------------------------
`ifndef LED_DRIVER_SERIAL_FRAME_WRITER_MACROS_SVH
`define LED_DRIVER_SERIAL_FRAME_WRITER_MACROS_SVH

// same-cycle implication, disabled in reset
`define LEDSW_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("ledsw implication check failed");

// next-cycle implication, disabled in reset
`define LEDSW_ASSERT_NXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("ledsw next-cycle check failed");

`endif

### rtl/ledsw_pkg.sv
// ----------------------------------------------------------------------------
// ledsw_pkg
// types, codes and the frame step table of the led serial frame writer
// ----------------------------------------------------------------------------
package ledsw_pkg;

  localparam int SHIFT_W     = 9;
  localparam int SHIFT_CNT_W = $clog2(SHIFT_W + 1);
  localparam int STEP_IDX_W  = 3;

  // operation codes
  localparam logic [2:0] OP_START      = 3'd0;
  localparam logic [2:0] OP_STOP       = 3'd1;
  localparam logic [2:0] OP_DATA_BEGIN = 3'd2;
  localparam logic [2:0] OP_DATA_BYTE  = 3'd3;
  localparam logic [2:0] OP_DATA_END   = 3'd4;
  localparam logic [2:0] OP_BRIGHT     = 3'd5;

  // line event codes
  localparam logic [1:0] EV_SELECT  = 2'd0;
  localparam logic [1:0] EV_BIT     = 2'd1;
  localparam logic [1:0] EV_RELEASE = 2'd2;

  // frame prefixes and commands
  localparam logic [2:0] PFX_CMD   = 3'h4;
  localparam logic [2:0] PFX_DATA  = 3'h5;
  localparam logic [7:0] C_DISABLE = 8'h00;
  localparam logic [7:0] C_ENABLE  = 8'h01;
  localparam logic [7:0] C_NMOS8   = 8'h20;
  localparam logic [7:0] C_LEDON   = 8'h03;
  localparam logic [7:0] C_BRIGHT  = 8'hA0;

  localparam logic [3:0] BRIGHT_RESET = 4'hF;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] value;
  } in_beat_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic       bit_value;
    logic       last;
  } out_beat_t;

  typedef enum logic [1:0] {
    STEP_NONE,
    STEP_SELECT,
    STEP_BITS,
    STEP_RELEASE
  } step_kind_t;

  typedef struct packed {
    step_kind_t             kind;
    logic [SHIFT_W-1:0]     word;
    logic [SHIFT_CNT_W-1:0] count;
    logic                   final_step;
  } step_t;

  typedef struct packed {
    logic                   load;
    logic                   shift;
    logic [SHIFT_W-1:0]     word;
    logic [SHIFT_CNT_W-1:0] count;
  } shift_ctl_t;

  typedef struct packed {
    logic                   msb;
    logic [SHIFT_CNT_W-1:0] remaining;
  } shift_stat_t;

  function automatic step_t mk_step(step_kind_t k, logic [SHIFT_W-1:0] w,
                                    logic [SHIFT_CNT_W-1:0] n, logic f);
    step_t s;
    s.kind       = k;
    s.word       = w;
    s.count      = n;
    s.final_step = f;
    return s;
  endfunction

  // select and release carry no bits
  function automatic step_t mk_line(step_kind_t k, logic f);
    return mk_step(k, '0, '0, f);
  endfunction

  // command byte msb first then the trailing zero bit
  function automatic step_t mk_cmd(logic [7:0] c, logic f);
    return mk_step(STEP_BITS, {c, 1'b0}, SHIFT_CNT_W'(SHIFT_W), f);
  endfunction

  function automatic step_t mk_prefix(logic [2:0] p);
    return mk_step(STEP_BITS, {p, {(SHIFT_W-3){1'b0}}}, SHIFT_CNT_W'(3), 1'b0);
  endfunction

  // nibbles go out low first, each lsb first: the byte reversed, msb first
  function automatic step_t mk_byte(logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7-i] = v[i];
    end
    return mk_step(STEP_BITS, {r, 1'b0}, SHIFT_CNT_W'(8), 1'b1);
  endfunction

  function automatic step_t step_lookup(logic [2:0] op, logic [STEP_IDX_W-1:0] idx,
                                        logic [3:0] bright, logic [7:0] value);
    step_t s;
    s = mk_line(STEP_NONE, 1'b1);
    unique case (op) inside
      OP_START: begin
        unique case (idx)
          3'd0: s = mk_line(STEP_SELECT, 1'b0);
          3'd1: s = mk_prefix(PFX_CMD);
          3'd2: s = mk_cmd(C_DISABLE, 1'b0);
          3'd3: s = mk_cmd(C_NMOS8, 1'b0);
          3'd4: s = mk_cmd(C_ENABLE, 1'b0);
          3'd5: s = mk_cmd(C_LEDON, 1'b0);
          3'd6: s = mk_cmd(C_BRIGHT | {4'h0, bright}, 1'b0);
          default: s = mk_line(STEP_RELEASE, 1'b1);
        endcase
      end
      OP_STOP, OP_BRIGHT: begin
        unique case (idx)
          3'd0: s = mk_line(STEP_SELECT, 1'b0);
          3'd1: s = mk_prefix(PFX_CMD);
          3'd2: s = (op == OP_STOP) ? mk_cmd(C_DISABLE, 1'b0)
                                    : mk_cmd(C_BRIGHT | {4'h0, value[3:0]}, 1'b0);
          default: s = mk_line(STEP_RELEASE, 1'b1);
        endcase
      end
      OP_DATA_BEGIN: begin
        unique case (idx)
          3'd0: s = mk_line(STEP_SELECT, 1'b0);
          3'd1: s = mk_prefix(PFX_DATA);
          default: s = mk_step(STEP_BITS, '0, SHIFT_CNT_W'(7), 1'b1);
        endcase
      end
      OP_DATA_BYTE: s = mk_byte(value);
      OP_DATA_END:  s = mk_line(STEP_RELEASE, 1'b1);
      default:      s = mk_line(STEP_NONE, 1'b1);
    endcase
    return s;
  endfunction

endpackage

### rtl/led_driver_serial_frame_writer.sv
// ----------------------------------------------------------------------------
// led_driver_serial_frame_writer
// turns led matrix driver operations into chip select / data bit line events
// ----------------------------------------------------------------------------
// usage
// - in channel (in_valid/in_ready/in_data): one beat is one operation, op and
//   value; in_ready is high only while the sequencer is idle
// - out channel (out_valid/out_ready/out_data): one beat per line event,
//   last marks the final event of the operation
// - cfg_wr_en/cfg_wr_data set the brightness used by the start sequence;
//   write only while idle
// - steps: an operation walks a short step list; a select or release step
//   emits its event directly, a bit step loads its word into the shared
//   shift register and then shifts the bits out msb first, one per event
// - the first event passes the step state and then the event register;
//   a data byte first takes a load step, then enters the shift state
// - unused op codes are accepted and produce no events
// - reset clears the sequencer and output register, brightness returns to 15
// - a stall on out_ready holds the event register and the sequencer at its
//   next event (a load step still runs); no event is dropped or repeated
// ----------------------------------------------------------------------------
`include "led_driver_serial_frame_writer_macros.svh"

module led_driver_serial_frame_writer (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ledsw_pkg::in_beat_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ledsw_pkg::out_beat_t out_data,
  input  logic                 cfg_wr_en,
  input  logic [3:0]           cfg_wr_data
);
  import ledsw_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_STEP,
    S_SHIFT
  } state_t;

  state_t                state;
  logic [STEP_IDX_W-1:0] idx;
  logic [2:0]            op_r;
  logic [7:0]            value_r;
  logic [3:0]            bright;

  step_t       cur;
  shift_ctl_t  sh_ctl;
  shift_stat_t sh_stat;
  logic        out_free;
  logic        emit;
  out_beat_t   emit_beat;
  logic        step_done;

  // the one shift unit every bit step runs through
  ledsw_shifter u_shifter (
    .clk  (clk),
    .rst  (rst),
    .ctl  (sh_ctl),
    .stat (sh_stat)
  );

  assign in_ready = (state == S_IDLE);
  // output register can take a new event this cycle
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cur       = step_lookup(op_r, idx, bright, value_r);
    sh_ctl    = '0;
    emit      = 1'b0;
    emit_beat = '0;
    step_done = 1'b0;
    unique case (state)
      S_STEP: begin
        unique case (cur.kind) inside
          STEP_SELECT, STEP_RELEASE: begin
            if (out_free) begin
              emit                 = 1'b1;
              emit_beat.event_kind = (cur.kind == STEP_SELECT) ? EV_SELECT : EV_RELEASE;
              emit_beat.last       = cur.final_step;
              step_done            = 1'b1;
            end
          end
          STEP_BITS: begin
            // load the word and move to the shift state
            sh_ctl.load  = 1'b1;
            sh_ctl.word  = cur.word;
            sh_ctl.count = cur.count;
          end
          default: step_done = 1'b1;
        endcase
      end
      S_SHIFT: begin
        if (out_free) begin
          emit                 = 1'b1;
          emit_beat.event_kind = EV_BIT;
          emit_beat.bit_value  = sh_stat.msb;
          emit_beat.last       = cur.final_step && (sh_stat.remaining == SHIFT_CNT_W'(1));
          sh_ctl.shift         = 1'b1;
          step_done            = (sh_stat.remaining == SHIFT_CNT_W'(1));
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      out_valid <= 1'b0;
      bright    <= BRIGHT_RESET;
    end else begin
      if (cfg_wr_en) begin
        bright <= cfg_wr_data;
      end
      // event register: refill on emit, drain when taken
      if (emit) begin
        out_valid <= 1'b1;
        out_data  <= emit_beat;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_r    <= in_data.op;
            value_r <= in_data.value;
            idx     <= '0;
            state   <= S_STEP;
          end
        end
        S_STEP: begin
          if (cur.kind == STEP_BITS) begin
            state <= S_SHIFT;
          end else if (step_done) begin
            if (cur.final_step) begin
              state <= S_IDLE;
            end else begin
              idx <= idx + STEP_IDX_W'(1);
            end
          end
        end
        S_SHIFT: begin
          if (step_done) begin
            if (cur.final_step) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + STEP_IDX_W'(1);
              state <= S_STEP;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // an accepted operation always keeps the input closed for the next cycle
  `LEDSW_ASSERT_NXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)
  // the final event of an operation returns the sequencer to idle
  `LEDSW_ASSERT_NXT(a_idle_after_last, clk, rst, emit && emit_beat.last, in_ready)
  // shifting never runs on an empty shift register
  `LEDSW_ASSERT_IMP(a_shift_has_bits, clk, rst, state == S_SHIFT, sh_stat.remaining != '0)
  // select and release events carry a zero data bit
  `LEDSW_ASSERT_IMP(a_line_bit_zero, clk, rst,
                    out_valid && out_data.event_kind != EV_BIT, !out_data.bit_value)

endmodule

### rtl/ledsw_shifter.sv
// ----------------------------------------------------------------------------
// ledsw_shifter
// shared msb-first shift register with a bit counter
// ----------------------------------------------------------------------------
module ledsw_shifter (
  input  logic                 clk,
  input  logic                 rst,
  input  ledsw_pkg::shift_ctl_t  ctl,
  output ledsw_pkg::shift_stat_t stat
);
  import ledsw_pkg::*;

  logic [SHIFT_W-1:0]     word;
  logic [SHIFT_CNT_W-1:0] remaining;

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
    end else if (ctl.load) begin
      remaining <= ctl.count;
    end else if (ctl.shift && remaining != '0) begin
      remaining <= remaining - SHIFT_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      word <= ctl.word;
    end else if (ctl.shift) begin
      word <= {word[SHIFT_W-2:0], 1'b0};
    end
  end

  assign stat.msb       = word[SHIFT_W-1];
  assign stat.remaining = remaining;

endmodule

### test/led_driver_serial_frame_writer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_driver_serial_frame_writer_tb
// drives operation beats into the serial frame writer and checks every line
// event it emits against an in-bench prediction of the select / bit / release
// sequence, under random gaps on the input side and stalls on the output side
// ----------------------------------------------------------------------------
module led_driver_serial_frame_writer_tb;
  import ledsw_pkg::*;

  // op codes the block accepts but turns into no events
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  // cycles with no beat on either side before the run is called hung
  localparam int STALL_LIMIT = 4000;
  // time left after draining for a stray event to show up
  localparam int SETTLE_CYCLES = 60;
  // cycles allowed for an event-less op to clear before a register write
  localparam int QUIET_CYCLES = 8;

  // --------------------------------------------------------------------------
  // expected line events: predicts each op's event train, then matches the
  // events that come out against it in order
  // --------------------------------------------------------------------------
  class line_event_book;
    out_beat_t  expected_events[$];
    logic [3:0] start_bright;
    int         errors;
    int         ops_taken;
    int         events_matched;

    function new();
      start_bright   = BRIGHT_RESET;
      errors         = 0;
      ops_taken      = 0;
      events_matched = 0;
    endfunction

    function void push_event(logic [1:0] kind, logic bit_v);
      out_beat_t e;
      e.event_kind = kind;
      e.bit_value  = bit_v;
      e.last       = 1'b0;
      expected_events.push_back(e);
    endfunction

    // low n bits of word, msb first
    function void push_bits(logic [7:0] word, int n);
      for (int i = n - 1; i >= 0; i--) begin
        push_event(EV_BIT, word[i]);
      end
    endfunction

    // command byte msb first, then one pad zero
    function void push_command(logic [7:0] cmd);
      push_bits(cmd, 8);
      push_event(EV_BIT, 1'b0);
    endfunction

    function void take_op(in_beat_t beat);
      int        before_n;
      out_beat_t tail;
      before_n = expected_events.size();
      ops_taken++;
      case (beat.op)
        OP_START: begin
          push_event(EV_SELECT, 1'b0);
          push_bits({5'd0, PFX_CMD}, 3);
          push_command(C_DISABLE);
          push_command(C_NMOS8);
          push_command(C_ENABLE);
          push_command(C_LEDON);
          push_command(C_BRIGHT | {4'h0, start_bright});
          push_event(EV_RELEASE, 1'b0);
        end
        OP_STOP: begin
          push_event(EV_SELECT, 1'b0);
          push_bits({5'd0, PFX_CMD}, 3);
          push_command(C_DISABLE);
          push_event(EV_RELEASE, 1'b0);
        end
        OP_DATA_BEGIN: begin
          // select, data prefix, address zero
          push_event(EV_SELECT, 1'b0);
          push_bits({5'd0, PFX_DATA}, 3);
          push_bits(8'h00, 7);
        end
        OP_DATA_BYTE: begin
          // low nibble then high nibble, each lsb first
          for (int i = 0; i < 8; i++) begin
            push_event(EV_BIT, beat.value[i]);
          end
        end
        OP_DATA_END: begin
          push_event(EV_RELEASE, 1'b0);
        end
        OP_BRIGHT: begin
          push_event(EV_SELECT, 1'b0);
          push_bits({5'd0, PFX_CMD}, 3);
          push_command(C_BRIGHT | {4'h0, beat.value[3:0]});
          push_event(EV_RELEASE, 1'b0);
        end
        default: begin
        end
      endcase
      if (expected_events.size() > before_n) begin
        tail      = expected_events.pop_back();
        tail.last = 1'b1;
        expected_events.push_back(tail);
      end
    endfunction

    task report_error(string what, int got_v, int want_v);
      $display("[%0t] line event %0d: %s got %0d expected %0d",
               $time, events_matched, what, got_v, want_v);
      errors++;
    endtask

    task match_event(out_beat_t got);
      out_beat_t want;
      if (expected_events.size() == 0) begin
        report_error("unexpected event, kind", got.event_kind, -1);
      end else begin
        want = expected_events.pop_front();
        if (got.event_kind !== want.event_kind)
          report_error("event_kind", got.event_kind, want.event_kind);
        if (got.bit_value !== want.bit_value)
          report_error("bit_value", got.bit_value, want.bit_value);
        if (got.last !== want.last)
          report_error("last", got.last, want.last);
        events_matched++;
      end
    endtask

    function int pending();
      return expected_events.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block inputs, all known from time zero
  // --------------------------------------------------------------------------
  logic       clk         = 1'b0;
  logic       rst         = 1'b1;
  logic       in_valid    = 1'b0;
  logic       in_ready;
  in_beat_t   in_data     = '0;
  logic       out_valid;
  logic       out_ready   = 1'b0;
  out_beat_t  out_data;
  logic       cfg_wr_en   = 1'b0;
  logic [3:0] cfg_wr_data = 4'd0;

  line_event_book book;

  // idle odds in percent, changed per phase
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int stall_cycles   = 0;
  int ignored_ops    = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  led_driver_serial_frame_writer dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // receiver side: ready drops at random with the current stall odds
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // beat monitor: values read here are the ones the block saw at this edge
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      // ops first: an op's events never show up in its own accept cycle
      if (in_valid && in_ready)
        book.take_op(in_data);
      if (out_valid && out_ready)
        book.match_event(out_data);
    end
  end

  // hang detector
  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("led_driver_serial_frame_writer: mismatch");
    $finish;
  end

  // --------------------------------------------------------------------------
  // driving tasks
  // --------------------------------------------------------------------------

  // one op beat; valid stays up across back-to-back beats
  task send_op(logic [2:0] op, logic [7:0] value);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {op, value};
    do @(posedge clk); while (!in_ready);
    if (op == OP_SPARE_LO || op == OP_SPARE_HI)
      ignored_ops++;
  endtask

  task release_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // wait for every predicted event, then let an event-less op clear
  task wait_drained();
    release_input();
    while (book.pending() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task write_brightness(logic [3:0] level);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= level;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    book.start_bright = level;
  endtask

  // mostly well-formed traffic with random content, some noise and
  // frames that never get closed
  task random_phase(int n_ops, bit pause_midway);
    int         sent;
    int         pick;
    int         n_bytes;
    logic [2:0] op;
    bit         paused;
    sent   = 0;
    paused = 1'b0;
    while (sent < n_ops) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        n_bytes = $urandom_range(6, 1);
        send_op(OP_DATA_BEGIN, 8'($urandom));
        repeat (n_bytes) send_op(OP_DATA_BYTE, 8'($urandom));
        // now and then the frame is left open
        if ($urandom_range(9) != 0) begin
          send_op(OP_DATA_END, 8'($urandom));
          sent++;
        end
        sent += n_bytes + 1;
      end else if (pick < 58) begin
        send_op(OP_START, 8'($urandom));
        sent++;
      end else if (pick < 68) begin
        send_op(OP_STOP, 8'($urandom));
        sent++;
      end else if (pick < 82) begin
        send_op(OP_BRIGHT, 8'($urandom));
        sent++;
      end else begin
        op = 3'($urandom_range(7));
        send_op(op, 8'($urandom));
        if (op != OP_SPARE_LO && op != OP_SPARE_HI)
          sent++;
      end
      // sender holds off once until the output side has caught up
      if (pause_midway && !paused && sent >= n_ops / 2) begin
        paused = 1'b1;
        release_input();
        while (book.pending() != 0) @(posedge clk);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [3:0] mid_bright;
    book = new();

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // phase one: sender gaps now and then, receiver stalls a lot
    send_idle_pct  = 25;
    recv_stall_pct = 76;

    // directed: every op, field extremes, unused codes, ops out of frame order
    send_op(OP_START, 8'h00);           // brightness still at its reset level
    send_op(OP_STOP, 8'hFF);
    send_op(OP_DATA_BEGIN, 8'hFF);
    send_op(OP_DATA_BYTE, 8'h00);
    send_op(OP_DATA_BYTE, 8'hFF);
    send_op(OP_DATA_BYTE, 8'hA5);
    send_op(OP_DATA_BYTE, 8'h5A);
    send_op(OP_DATA_END, 8'h00);
    send_op(OP_BRIGHT, 8'h00);
    send_op(OP_BRIGHT, 8'h0F);
    send_op(OP_BRIGHT, 8'hF0);          // high nibble must be dropped
    send_op(OP_BRIGHT, 8'hFF);
    send_op(OP_SPARE_LO, 8'hFF);
    send_op(OP_SPARE_HI, 8'h00);
    send_op(OP_DATA_BYTE, 8'h3C);       // byte with no open frame
    send_op(OP_DATA_END, 8'hFF);
    send_op(OP_DATA_END, 8'h00);        // release twice in a row
    send_op(OP_DATA_BEGIN, 8'h00);
    send_op(OP_DATA_BEGIN, 8'h00);      // begin inside an open frame
    send_op(OP_START, 8'hFF);
    wait_drained();

    // lowest brightness, then random traffic
    write_brightness(4'd0);
    send_op(OP_START, 8'h00);
    random_phase(60, 1'b0);
    wait_drained();

    // phase two: sender mostly idle, receiver rarely stalls
    mid_bright = 4'($urandom_range(14, 1));
    write_brightness(mid_bright);
    send_idle_pct  = 76;
    recv_stall_pct = 25;
    send_op(OP_START, 8'h00);
    random_phase(65, 1'b1);
    wait_drained();

    // phase three: full rate on both sides, top brightness
    write_brightness(4'd15);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_op(OP_START, 8'h00);
    random_phase(65, 1'b0);
    send_op(OP_START, 8'h00);

    // drain, then give the block time to emit anything stray
    release_input();
    while (book.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("ran %0d op beats (%0d unused codes), checked %0d line events",
             book.ops_taken, ignored_ops, book.events_matched);
    $display("start brightness levels 15, 0, %0d and 15 under three idle mixes",
             mid_bright);
    if (book.errors == 0 && book.pending() == 0) begin
      $display("led_driver_serial_frame_writer: match");
    end else begin
      $display("led_driver_serial_frame_writer: mismatch");
    end
    $finish;
  end

endmodule
